/* rtl/shortest_path_to_best_goal_macros.svh */
// Assertion macros for the shortest-path block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SHORTEST_PATH_TO_BEST_GOAL_MACROS_SVH
`define SHORTEST_PATH_TO_BEST_GOAL_MACROS_SVH
// same-cycle implication
`define SPBG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SPBG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/spbg_pkg.sv */
// Shared constants, opcodes and controller/datapath interface structs.
// No dependencies.
package spbg_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_LINKS = 8;
  localparam int DEF_FRAC_BITS = 4;

  localparam int IDX_W      = 6;
  localparam int COORD_W    = 16;
  localparam int GCOST_W    = 16;
  localparam int COST_W     = 27;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_LINK = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN  = 2'd2;

  typedef enum logic [1:0] {
    ASEL_SCAN,
    ASEL_LINK,
    ASEL_CUR,
    ASEL_TRACE
  } addr_sel_t;

  typedef struct packed {
    logic      cap_req;
    logic      node_load;
    logic      lnk_wr;
    logic      lc_cur;
    logic      run_init;
    logic      scan_clr;
    logic      scan_min;
    logic      scan_goal;
    logic      expand;
    logic      exp_cap;
    logic      t_cap;
    logic      lk_chk;
    logic      sq;
    logic      sq_start;
    logic      lk_upd;
    logic      k_inc;
    logic      tr_init;
    logic      tr_next;
    logic      em_init;
    logic      em_load;
    logic      em_dec;
    logic      nf_load;
    addr_sel_t asel;
  } cmd_t;

  typedef struct packed {
    logic in_idx_ok;
    logic in_present;
    logic scan_last;
    logic have;
    logic k_done;
    logic lk_skip;
    logic sq_done;
    logic tr_at_start;
    logic tr_full;
    logic em_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/spbg_sqrt.sv */
// Bit-serial integer square root with remainder, one root bit per cycle.
// Depends on nothing.
module spbg_sqrt #(
  parameter int V_W = 41,
  localparam int RT_W = (V_W + 1) / 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [V_W-1:0]  v,
  output logic [RT_W-1:0] root,
  output logic [RT_W:0]   rem,
  output logic            done
);

  localparam int SV_W  = 2 * RT_W;
  localparam int REM_W = RT_W + 3;
  localparam int CW    = $clog2(RT_W) + 1;

  logic [SV_W-1:0]  rad_r;
  logic [REM_W-1:0] rem_r;
  logic [RT_W-1:0]  root_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SV_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(RT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= SV_W'(v);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      cnt_r <= cnt_r + 1'b1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign rem  = rem_r[RT_W:0];
  assign done = done_r;

endmodule

/* rtl/spbg_dp.sv */
// Datapath: graph memories, search registers, edge cost unit and output register.
// Depends on spbg_pkg and spbg_sqrt.
module spbg_dp import spbg_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_LINKS = DEF_MAX_LINKS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [IDX_W-1:0]          in_node_index,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_is_blocked,
  input  logic                      in_is_goal,
  input  logic [GCOST_W-1:0]        in_goal_cost,
  input  logic [IDX_W-1:0]          in_link_target,
  input  logic                      out_tready,
  output logic                      out_valid,
  output logic [IDX_W-1:0]          out_path_node,
  output logic [IDX_W-1:0]          out_goal_node,
  output logic [COST_W-1:0]         out_travel_cost,
  output logic                      out_found,
  output logic                      out_last
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int XW     = ((NODE_W > IDX_W) ? NODE_W : IDX_W) + 1;
  localparam int LC_W   = $clog2(MAX_LINKS + 1);
  localparam int LT_D   = MAX_NODES * MAX_LINKS;
  localparam int LT_W   = $clog2(LT_D);
  localparam int SQ_W   = 2 * COORD_W;
  localparam int V_W    = SQ_W + 1 + 2 * FRAC_BITS;
  localparam int RT_W   = (V_W + 1) / 2;
  localparam int EC_W   = RT_W + 1;
  localparam int SUM_W  = ((EC_W > COST_W) ? EC_W : COST_W) + 1;
  localparam logic [EC_W-1:0] ONE = EC_W'(1) << FRAC_BITS;

  // graph store
  logic signed [COORD_W-1:0] x_mem   [MAX_NODES];
  logic signed [COORD_W-1:0] y_mem   [MAX_NODES];
  logic [1:0]                fl_mem  [MAX_NODES];
  logic [GCOST_W-1:0]        sec_mem [MAX_NODES];
  logic [COST_W-1:0]         dist_mem[MAX_NODES];
  logic [NODE_W-1:0]         pred_mem[MAX_NODES];
  logic [NODE_W-1:0]         path_mem[MAX_NODES];
  logic [LC_W-1:0]           lc_mem  [MAX_NODES];
  logic [IDX_W-1:0]          lt_mem  [LT_D];

  logic [MAX_NODES-1:0] present_r, lcv_r, reached_r, visited_r;

  logic signed [COORD_W-1:0] x_q, y_q;
  logic [1:0]                fl_q;
  logic [GCOST_W-1:0]        sec_q;
  logic [COST_W-1:0]         dist_q;
  logic [NODE_W-1:0]         pred_q, path_q;
  logic [LC_W-1:0]           lc_q;
  logic                      lcv_q;
  logic [IDX_W-1:0]          lt_q;

  logic [IDX_W-1:0]  req_node_r, req_tgt_r;
  logic [NODE_W-1:0] start_r, cur_r, best_r, trace_r, emit_r;
  logic [COST_W-1:0] cur_dist_r, best_dist_r, tdist_r;
  logic [GCOST_W-1:0] best_sec_r;
  logic [NODE_W-1:0] tpred_r;
  logic [NODE_W:0]   scan_i_r, len_r;
  logic              have_r;
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r;
  logic [LC_W-1:0]   n_r, k_r;
  logic [IDX_W-1:0]  t_r;
  logic [COORD_W-1:0] adx_r, ady_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;

  logic [COST_W-1:0]  out_cost_r;
  logic [IDX_W-1:0]   out_path_r, out_goal_r;
  logic               out_valid_r, out_found_r, out_last_r;

  logic [NODE_W-1:0] in_n, req_n, t_n, si, rd_addr, lc_addr;
  logic              req_ok, t_ok;
  logic [LC_W-1:0]   cnt_eff;
  logic [LT_W-1:0]   lt_ra;
  logic signed [COORD_W:0] dx, dy;
  logic [V_W-1:0]    v;
  logic [RT_W-1:0]   root;
  logic [RT_W:0]     rem;
  logic              sq_done;
  logic [EC_W-1:0]   ec_rnd, ec;
  logic [SUM_W-1:0]  sum;
  logic [COST_W-1:0] cand;
  logic              relax, scan_c, scan_better, goal_c, goal_better, out_free;

  assign in_n    = NODE_W'(in_node_index);
  assign req_n   = NODE_W'(req_node_r);
  assign t_n     = NODE_W'(t_r);
  assign si      = NODE_W'(scan_i_r);
  assign req_ok  = XW'(req_node_r) < XW'(MAX_NODES);
  assign t_ok    = XW'(t_r) < XW'(MAX_NODES);
  assign cnt_eff = lcv_q ? lc_q : '0;
  assign lt_ra   = LT_W'(cur_r * MAX_LINKS) + LT_W'(k_r);
  assign lc_addr = cmd.lc_cur ? cur_r : req_n;

  always_comb begin
    case (cmd.asel)
      ASEL_SCAN:  rd_addr = si;
      ASEL_LINK:  rd_addr = NODE_W'(lt_q);
      ASEL_CUR:   rd_addr = cur_r;
      ASEL_TRACE: rd_addr = trace_r;
      default:    rd_addr = si;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.node_load) begin
      x_mem[in_n]   <= in_pos_x;
      y_mem[in_n]   <= in_pos_y;
      fl_mem[in_n]  <= {in_is_goal, in_is_blocked};
      sec_mem[in_n] <= in_goal_cost;
      lc_mem[in_n]  <= '0;
    end else if (cmd.lnk_wr && req_ok && cnt_eff < LC_W'(MAX_LINKS)) begin
      lt_mem[LT_W'(req_n * MAX_LINKS) + LT_W'(cnt_eff)] <= req_tgt_r;
      lc_mem[req_n] <= cnt_eff + 1'b1;
    end
    if (cmd.run_init) begin
      dist_mem[NODE_W'(req_node_r)] <= '0;
      pred_mem[NODE_W'(req_node_r)] <= NODE_W'(req_node_r);
    end else if (cmd.lk_upd && relax) begin
      dist_mem[t_n] <= cand;
      pred_mem[t_n] <= cur_r;
    end
    if (cmd.tr_init) begin
      path_mem[0] <= best_r;
    end else if (cmd.tr_next) begin
      path_mem[NODE_W'(len_r)] <= pred_q;
    end
    x_q    <= x_mem[rd_addr];
    y_q    <= y_mem[rd_addr];
    fl_q   <= fl_mem[rd_addr];
    sec_q  <= sec_mem[rd_addr];
    dist_q <= dist_mem[rd_addr];
    pred_q <= pred_mem[rd_addr];
    path_q <= path_mem[emit_r];
    lc_q   <= lc_mem[lc_addr];
    lcv_q  <= lcv_r[lc_addr];
    lt_q   <= lt_mem[lt_ra];
  end

  // per-node flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      lcv_r     <= '0;
      reached_r <= '0;
      visited_r <= '0;
    end else begin
      if (cmd.node_load) begin
        present_r[in_n] <= 1'b1;
        lcv_r[in_n]     <= 1'b1;
      end else if (cmd.lnk_wr && req_ok) begin
        lcv_r[req_n] <= 1'b1;
      end
      if (cmd.run_init) begin
        reached_r        <= '0;
        visited_r        <= '0;
        reached_r[req_n] <= 1'b1;
      end else begin
        if (cmd.expand) visited_r[best_r] <= 1'b1;
        if (cmd.lk_upd && relax) reached_r[t_n] <= 1'b1;
      end
    end
  end

  // node selection scans
  assign scan_c      = reached_r[si] && !visited_r[si];
  assign scan_better = !have_r || dist_q < best_dist_r;
  assign goal_c      = present_r[si] && fl_q[1] && reached_r[si];
  assign goal_better = !have_r || dist_q < best_dist_r ||
                       (dist_q == best_dist_r && sec_q < best_sec_r);

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_node_r <= in_node_index;
      req_tgt_r  <= in_link_target;
    end
    if (cmd.run_init) start_r <= req_n;
    if (cmd.run_init || cmd.scan_clr) begin
      scan_i_r <= '0;
      have_r   <= 1'b0;
    end else if (cmd.scan_min || cmd.scan_goal) begin
      scan_i_r <= scan_i_r + 1'b1;
      if ((cmd.scan_min && scan_c && scan_better) ||
          (cmd.scan_goal && goal_c && goal_better)) begin
        best_r      <= si;
        best_dist_r <= dist_q;
        best_sec_r  <= sec_q;
        have_r      <= 1'b1;
      end
    end
    if (cmd.expand) begin
      cur_r      <= best_r;
      cur_dist_r <= best_dist_r;
    end
    if (cmd.exp_cap) begin
      cur_x_r <= x_q;
      cur_y_r <= y_q;
      n_r     <= cnt_eff;
      k_r     <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.t_cap) t_r <= lt_q;
    if (cmd.lk_chk) begin
      tdist_r <= dist_q;
      tpred_r <= pred_q;
      adx_r   <= dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
      ady_r   <= dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
    end
    if (cmd.sq) begin
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
    end
    if (cmd.tr_init) begin
      trace_r <= best_r;
      len_r   <= (NODE_W+1)'(1);
    end else if (cmd.tr_next) begin
      trace_r <= pred_q;
      len_r   <= len_r + 1'b1;
    end
    if (cmd.em_init) emit_r <= NODE_W'(len_r - 1'b1);
    else if (cmd.em_dec) emit_r <= emit_r - 1'b1;
  end

  // edge cost
  assign dx = {cur_x_r[COORD_W-1], cur_x_r} - {x_q[COORD_W-1], x_q};
  assign dy = {cur_y_r[COORD_W-1], cur_y_r} - {y_q[COORD_W-1], y_q};
  assign v  = V_W'((SQ_W+1)'(sqx_r) + (SQ_W+1)'(sqy_r)) << (2 * FRAC_BITS);

  spbg_sqrt #(.V_W(V_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_start),
    .v     (v),
    .root  (root),
    .rem   (rem),
    .done  (sq_done)
  );

  assign ec_rnd = EC_W'(root) + EC_W'(rem > EC_W'(root));
  assign ec     = (ec_rnd < ONE) ? ONE : ec_rnd;
  assign sum    = SUM_W'(cur_dist_r) + SUM_W'(ec);
  assign cand   = (sum > SUM_W'(COST_MAX)) ? COST_MAX : COST_W'(sum);
  assign relax  = !reached_r[t_n] || cand < tdist_r ||
                  (cand == tdist_r && cur_r < tpred_r);

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.em_load || cmd.nf_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      out_path_r  <= IDX_W'(path_q);
      out_goal_r  <= IDX_W'(best_r);
      out_cost_r  <= best_dist_r;
      out_found_r <= 1'b1;
      out_last_r  <= (emit_r == '0);
    end else if (cmd.nf_load) begin
      out_path_r  <= '0;
      out_goal_r  <= '0;
      out_cost_r  <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_path_node   = out_path_r;
  assign out_goal_node   = out_goal_r;
  assign out_travel_cost = out_cost_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;

  // status
  assign sts.in_idx_ok   = XW'(in_node_index) < XW'(MAX_NODES);
  assign sts.in_present  = present_r[in_n];
  assign sts.scan_last   = scan_i_r == (NODE_W+1)'(MAX_NODES - 1);
  assign sts.have        = have_r;
  assign sts.k_done      = k_r == n_r;
  assign sts.lk_skip     = !t_ok || !present_r[t_n] ||
                           (t_n != start_r && fl_q[0]) || visited_r[t_n];
  assign sts.sq_done     = sq_done;
  assign sts.tr_at_start = trace_r == start_r;
  assign sts.tr_full     = len_r >= (NODE_W+1)'(MAX_NODES);
  assign sts.em_last     = emit_r == '0;
  assign sts.out_free    = out_free;

endmodule

/* rtl/spbg_ctrl.sv */
// Controller FSM: sequences loads, the search, goal pick, path trace and emit.
// Depends on spbg_pkg.
module spbg_ctrl import spbg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [OP_W-1:0] in_opcode,
  output logic            in_tready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_LNK_RD, S_LNK_WR, S_RUN_INIT, S_SCAN_RD, S_SCAN_CMP, S_SCAN_END,
    S_EXP_RD, S_EXP_CAP, S_LK_CHKN, S_LK_T, S_LK_CHK, S_LK_SQ, S_LK_SUM,
    S_LK_SQRT, S_LK_UPD, S_GS_RD, S_GS_CMP, S_GS_END, S_TR_CHK, S_TR_NXT,
    S_EM_RD, S_EM_LD, S_NF
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap_req = 1'b1;
          case (in_opcode)
            OP_LOAD: cmd.node_load = sts.in_idx_ok;
            OP_LINK: state_nxt = S_LNK_RD;
            OP_RUN:  state_nxt = (sts.in_idx_ok && sts.in_present) ? S_RUN_INIT : S_NF;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LNK_RD: state_nxt = S_LNK_WR;
      S_LNK_WR: begin
        cmd.lnk_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RUN_INIT: begin
        cmd.run_init = 1'b1;
        state_nxt    = S_SCAN_RD;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        cmd.scan_min = 1'b1;
        state_nxt    = sts.scan_last ? S_SCAN_END : S_SCAN_RD;
      end
      S_SCAN_END: begin
        if (sts.have) begin
          cmd.expand = 1'b1;
          state_nxt  = S_EXP_RD;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_GS_RD;
        end
      end
      S_EXP_RD: begin
        cmd.asel   = ASEL_CUR;
        cmd.lc_cur = 1'b1;
        state_nxt  = S_EXP_CAP;
      end
      S_EXP_CAP: begin
        cmd.exp_cap = 1'b1;
        state_nxt   = S_LK_CHKN;
      end
      S_LK_CHKN: begin
        if (sts.k_done) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN_RD;
        end else begin
          state_nxt = S_LK_T;
        end
      end
      S_LK_T: begin
        cmd.asel  = ASEL_LINK;
        cmd.t_cap = 1'b1;
        state_nxt = S_LK_CHK;
      end
      S_LK_CHK: begin
        cmd.lk_chk = 1'b1;
        if (sts.lk_skip) begin
          cmd.k_inc = 1'b1;
          state_nxt = S_LK_CHKN;
        end else begin
          state_nxt = S_LK_SQ;
        end
      end
      S_LK_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_LK_SUM;
      end
      S_LK_SUM: begin
        cmd.sq_start = 1'b1;
        state_nxt    = S_LK_SQRT;
      end
      S_LK_SQRT: if (sts.sq_done) state_nxt = S_LK_UPD;
      S_LK_UPD: begin
        cmd.lk_upd = 1'b1;
        cmd.k_inc  = 1'b1;
        state_nxt  = S_LK_CHKN;
      end
      S_GS_RD: state_nxt = S_GS_CMP;
      S_GS_CMP: begin
        cmd.scan_goal = 1'b1;
        state_nxt     = sts.scan_last ? S_GS_END : S_GS_RD;
      end
      S_GS_END: begin
        if (sts.have) begin
          cmd.tr_init = 1'b1;
          state_nxt   = S_TR_CHK;
        end else begin
          state_nxt = S_NF;
        end
      end
      S_TR_CHK: begin
        cmd.asel = ASEL_TRACE;
        if (sts.tr_at_start) begin
          cmd.em_init = 1'b1;
          state_nxt   = S_EM_RD;
        end else if (sts.tr_full) begin
          state_nxt = S_NF;
        end else begin
          state_nxt = S_TR_NXT;
        end
      end
      S_TR_NXT: begin
        cmd.tr_next = 1'b1;
        state_nxt   = S_TR_CHK;
      end
      S_EM_RD: state_nxt = S_EM_LD;
      S_EM_LD: begin
        if (sts.out_free) begin
          cmd.em_load = 1'b1;
          if (sts.em_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.em_dec = 1'b1;
            state_nxt  = S_EM_RD;
          end
        end
      end
      S_NF: begin
        if (sts.out_free) begin
          cmd.nf_load = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/shortest_path_to_best_goal.sv */
// Shortest path to the best goal: graph loader and Dijkstra search engine.
// Input requests carry node records, links or a run; a run returns the path.
// A node record leaves the input ready; a link holds the input through S_LNK_RD
// and S_LNK_WR, and a run on a missing start holds it until its not-found
// result is registered. Any other run holds the input until its last result is
// registered; its length is set by the serial node scan over the distance
// memory and the bit-serial square root (21 root bits at Q.4) per link. Each
// path result is read from the path memory in S_EM_RD and then registered in
// S_EM_LD.
// Results leave through a registered output; each path node waits there until
// taken, so a stalled receiver holds the search engine at that node while
// loads may enter once the final result is registered.
// Reset clears the node-present, link-count valid and search flags at once;
// no clearing pass is needed. Missing start or no reachable goal gives one
// result with found low and last high.
// Depends on spbg_pkg, spbg_ctrl, spbg_dp, spbg_sqrt and the macro header.
`include "shortest_path_to_best_goal_macros.svh"
module shortest_path_to_best_goal import spbg_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_LINKS = DEF_MAX_LINKS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // node_index[5:0] pos_x[21:6] pos_y[37:22] is_blocked[38] is_goal[39]
  // goal_cost[55:40] link_target[61:56]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // path_node[5:0] goal_node[11:6] travel_cost[38:12]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // found[0]
  output logic                  out_tuser,
  output logic                  out_tlast
);

  cmd_t cmd;
  sts_t sts;

  logic [IDX_W-1:0]  path_node, goal_node;
  logic [COST_W-1:0] travel_cost;

  spbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spbg_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_LINKS (MAX_LINKS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_node_index   (in_tdata[5:0]),
    .in_pos_x        (in_tdata[21:6]),
    .in_pos_y        (in_tdata[37:22]),
    .in_is_blocked   (in_tdata[38]),
    .in_is_goal      (in_tdata[39]),
    .in_goal_cost    (in_tdata[55:40]),
    .in_link_target  (in_tdata[61:56]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_path_node   (path_node),
    .out_goal_node   (goal_node),
    .out_travel_cost (travel_cost),
    .out_found       (out_tuser),
    .out_last        (out_tlast)
  );

  assign out_tdata = {1'b0, travel_cost, goal_node, path_node};

  `SPBG_ASSERT_IMP(a_nf_last, out_tvalid && !out_tuser, out_tlast, "not-found result without last")
  `SPBG_ASSERT_IMP(a_nf_zero, out_tvalid && !out_tuser, out_tdata == '0, "not-found result nonzero")
  `SPBG_ASSERT_NXT(a_run_busy, in_tvalid && in_tready && in_tuser == OP_RUN, !in_tready, "run not blocking input")

endmodule

/* test/tb_shortest_path_to_best_goal.sv */
// Testbench for shortest_path_to_best_goal: loads graphs, runs searches and
// checks every path result against an in-bench Dijkstra predictor.
// Depends on spbg_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_shortest_path_to_best_goal;
  import spbg_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int N = DEF_MAX_NODES;
  localparam int L = DEF_MAX_LINKS;
  localparam int WD_LIMIT = 400000;

  typedef struct {
    logic [IDX_W-1:0]  path;
    logic [IDX_W-1:0]  goal;
    logic [COST_W-1:0] cost;
    logic              found;
    logic              last;
  } hop_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser, out_tlast;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [OP_W-1:0] in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  shortest_path_to_best_goal dut (.*);

  // graph mirror
  bit                 present [N];
  logic signed [15:0] nx [N];
  logic signed [15:0] ny [N];
  bit                 blk [N];
  bit                 gl [N];
  logic [15:0]        sc [N];
  logic [5:0]         lt [N][L];
  int                 lc [N];

  hop_t path_q[$];
  int errors = 0, n_req = 0, n_hops = 0, n_runs = 0;
  int send_idle = 0, recv_stall = 0, hold_left = 0, wd = 0;
  int hold_reqs = 0, hold_seen = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic mismatch(string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [COST_W-1:0] hop_cost(int a, int b);
    longint dx, dy;
    longint unsigned v, s;
    dx = longint'(nx[a]) - longint'(nx[b]);
    dy = longint'(ny[a]) - longint'(ny[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    v = unsigned'(dx * dx + dy * dy) << (2 * DEF_FRAC_BITS);
    s = isqrt(v);
    if (v - s * s > s) s++;
    if (s < (64'd1 << DEF_FRAC_BITS)) s = 64'd1 << DEF_FRAC_BITS;
    if (s > COST_MAX) s = COST_MAX;
    return s[COST_W-1:0];
  endfunction

  function automatic void push_not_found();
    hop_t h;
    h.path = 0; h.goal = 0; h.cost = 0; h.found = 0; h.last = 1;
    path_q.push_back(h);
  endfunction

  function automatic void predict_search(int st);
    logic [COST_W-1:0] pcost [N];
    bit rch [N], vis [N];
    int pred [N], trace [$];
    int cur, best, t;
    bit have;
    longint unsigned cand;
    hop_t h;
    n_runs++;
    if (!present[st]) begin
      push_not_found();
      return;
    end
    foreach (pcost[i]) begin pcost[i] = 0; rch[i] = 0; vis[i] = 0; pred[i] = 0; end
    rch[st] = 1;
    pred[st] = st;
    forever begin
      have = 0;
      cur = 0;
      for (int i = 0; i < N; i++)
        if (rch[i] && !vis[i] && (!have || pcost[i] < pcost[cur])) begin
          cur = i;
          have = 1;
        end
      if (!have) break;
      vis[cur] = 1;
      for (int k = 0; k < lc[cur]; k++) begin
        t = int'(lt[cur][k]);
        if (!present[t] || (t != st && blk[t]) || vis[t]) continue;
        cand = pcost[cur] + hop_cost(cur, t);
        if (cand > COST_MAX) cand = COST_MAX;
        if (!rch[t] || cand < pcost[t] || (cand == pcost[t] && cur < pred[t])) begin
          pcost[t] = cand[COST_W-1:0];
          pred[t] = cur;
          rch[t] = 1;
        end
      end
    end
    have = 0;
    best = 0;
    for (int i = 0; i < N; i++) begin
      if (!present[i] || !gl[i] || !rch[i]) continue;
      if (!have || pcost[i] < pcost[best] ||
          (pcost[i] == pcost[best] && sc[i] < sc[best])) begin
        best = i;
        have = 1;
      end
    end
    if (!have) begin
      push_not_found();
      return;
    end
    cur = best;
    trace.push_front(cur);
    while (cur != st) begin
      if (trace.size() >= N) begin
        push_not_found();
        return;
      end
      cur = pred[cur];
      trace.push_front(cur);
    end
    foreach (trace[i]) begin
      h.path = IDX_W'(trace[i]); h.goal = IDX_W'(best); h.cost = pcost[best]; h.found = 1;
      h.last = (i == trace.size() - 1);
      path_q.push_back(h);
    end
  endfunction

  function automatic void apply_req(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] d);
    int idx = int'(d[5:0]);
    case (op)
      OP_LOAD: begin
        present[idx] = 1;
        nx[idx] = d[21:6];
        ny[idx] = d[37:22];
        blk[idx] = d[38];
        gl[idx] = d[39];
        sc[idx] = d[55:40];
        lc[idx] = 0;
      end
      OP_LINK: if (lc[idx] < L) begin
        lt[idx][lc[idx]] = d[61:56];
        lc[idx]++;
      end
      OP_RUN: predict_search(idx);
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_req(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] d);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = op;
    in_tdata = d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_req(op, d);
    n_req++;
    @(negedge clk);
    in_tvalid = 0;
  endtask

  function automatic logic [IN_DATA_W-1:0] node_rec(int idx, int x, int y, bit b, bit g,
                                                    int gc);
    logic [IN_DATA_W-1:0] d = '0;
    d[5:0] = 6'(idx); d[21:6] = 16'(x); d[37:22] = 16'(y); d[38] = b; d[39] = g;
    d[55:40] = 16'(gc);
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] link_rec(int src, int dst);
    logic [IN_DATA_W-1:0] d = '0;
    d[5:0] = 6'(src); d[61:56] = 6'(dst);
    return d;
  endfunction

  task automatic wait_drain();
    while (path_q.size() != 0) @(negedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 0;
    end else out_tready = ($urandom_range(0, 99) >= recv_stall);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    hop_t e;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wd = 0;
      else wd++;
      if (wd >= WD_LIMIT) begin
        $display("tb: watchdog expired");
        $display("tb: failure");
        $finish;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_hops++;
      if (path_q.size() == 0) mismatch("result with nothing expected");
      else begin
        e = path_q.pop_front();
        if (out_tdata[5:0] !== e.path)
          mismatch($sformatf("path_node %0d exp %0d", out_tdata[5:0], e.path));
        if (out_tdata[11:6] !== e.goal)
          mismatch($sformatf("goal_node %0d exp %0d", out_tdata[11:6], e.goal));
        if (out_tdata[38:12] !== e.cost)
          mismatch($sformatf("travel_cost %0d exp %0d", out_tdata[38:12], e.cost));
        if (out_tuser !== e.found)
          mismatch($sformatf("found %b exp %b", out_tuser, e.found));
        if (out_tlast !== e.last)
          mismatch($sformatf("last %b exp %b", out_tlast, e.last));
      end
    end
  end

  task automatic test_directed();
    send_req(OP_RUN, 64'd5);                                // start never loaded
    send_req(OP_LINK, link_rec(0, 1));                      // cleared by later load
    send_req(OP_LOAD, node_rec(0, -32768, -32768, 1, 0, 0)); // blocked start
    send_req(OP_LOAD, node_rec(1, 32767, 32767, 0, 1, 16'hFFFF));
    send_req(OP_RUN, 64'd0);                                // no links, not found
    send_req(OP_LINK, link_rec(0, 1));
    send_req(OP_LINK, link_rec(1, 0));                      // back to visited start
    send_req(OP_RUN, 64'd0);
    send_req(OP_LOAD, node_rec(2, 0, 0, 1, 1, 0));          // blocked goal
    send_req(OP_LINK, link_rec(0, 2));
    send_req(OP_LINK, link_rec(0, 50));                     // missing target
    send_req(OP_NOP, 64'hFFFF_FFFF_FFFF_FFFF >> 2);
    send_req(OP_RUN, 64'd0);
    send_req(OP_LOAD, node_rec(4, 5, 5, 0, 1, 7));          // start is a goal
    send_req(OP_RUN, 64'd4);
    for (int i = 0; i < 9; i++) send_req(OP_LINK, link_rec(4, 1)); // list overflow
    send_req(OP_RUN, 64'd1);
    wait_drain();
  endtask

  task automatic test_random_graphs(int idle_s, int stall_r, int reqs);
    int cnt = 0, nn, idx, x, y;
    send_idle = idle_s;
    recv_stall = stall_r;
    while (cnt < reqs) begin
      nn = $urandom_range(3, 10);
      for (int i = 0; i < nn; i++) begin
        idx = $urandom_range(0, 15) + (($urandom_range(0, 9) == 0) ? 48 : 0);
        if ($urandom_range(0, 4) == 0) begin x = $urandom; y = $urandom; end
        else begin x = $urandom_range(0, 40) - 20; y = $urandom_range(0, 40) - 20; end
        send_req(OP_LOAD, node_rec(idx, x, y, $urandom_range(0, 4) == 0,
                                   $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0 ?
                                   $urandom : $urandom_range(0, 3)));
        cnt++;
      end
      for (int i = 0; i < 2 * nn; i++) begin
        idx = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
        send_req(OP_LINK, link_rec($urandom_range(0, 15), idx));
        cnt++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_req(OP_NOP, {$urandom, $urandom} >> 2);
        cnt++;
      end
      for (int i = 0; i < 2; i++) begin
        send_req(OP_RUN, IN_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                                : $urandom_range(0, 15)));
        cnt++;
      end
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_stall = 0;
    @(negedge clk);
    hold_reqs++;
    send_req(OP_RUN, 64'd0);
    for (int i = 0; i < 6; i++) send_req(OP_RUN, IN_DATA_W'($urandom_range(0, 15)));
    wait_drain();
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = '0;
    in_tdata = '0;
    foreach (present[i]) begin present[i] = 0; lc[i] = 0; end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_directed();
    test_random_graphs(0, 0, 20);
    test_random_graphs(53, 0, 20);
    test_random_graphs(0, 53, 20);
    test_random_graphs(21, 21, 20);
    test_backpressure();
    repeat (200) @(negedge clk);
    $display("tb: %0d requests, %0d searches, %0d path results checked, %0d errors",
             n_req, n_runs, n_hops, errors);
    $display("tb: covered directed corner graphs, random graphs under idle/stall and a long hold-off");
    if (errors == 0 && path_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
